>>> rtl/core/dead_reckoning_integrator_top_defines.svh
// Assertion macros for the dead-reckoning integrator.
`ifndef DEAD_RECKONING_INTEGRATOR_TOP_DEFINES_SVH
`define DEAD_RECKONING_INTEGRATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and muted during reset.
`define DRI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and muted during reset.
`define DRI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/dri_pkg.sv
// Shared types, widths and the CORDIC arctangent table of the dead-reckoning integrator.
package dri_pkg;

	localparam int HEAD_W = 16;
	localparam int ACCEL_W = 16;
	localparam int VEL_W = 32;
	localparam int POS_W = 48;
	// Rotation vector in Q8.24 with headroom for the CORDIC gain.
	localparam int XY_W = 34;
	// Velocity increment after rounding away eight fraction bits.
	localparam int DX_W = XY_W - 8;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANGLE_BITS_DEF = 16;

	localparam logic signed [17:0] GAIN_Q16 = 18'sd39797;

	localparam logic [31:0] ATAN_TURN32 [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Arctangent of 2^-k in units of 2^-abits turn, rounded half up.
	function automatic logic [32:0] atan_step(input int k, input int abits);
		logic [32:0] sum;
		sum = {1'b0, ATAN_TURN32[k]} + (33'd1 << (31 - abits));
		return sum >> (32 - abits);
	endfunction

	typedef struct packed {
		logic signed [ACCEL_W-1:0] acceleration;
		logic signed [HEAD_W-1:0]  turn_step;
	} dri_in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position_x;
		logic signed [POS_W-1:0] position_y;
		logic signed [VEL_W-1:0] velocity_x;
		logic signed [VEL_W-1:0] velocity_y;
		logic [HEAD_W-1:0]       heading;
	} dri_out_t;

endpackage

>>> rtl/core/dri_cordic_cell.sv
// One rotation-mode CORDIC cell with its own valid bit and output register.
module dri_cordic_cell import dri_pkg::*; #(
	parameter int STAGE      = 0,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  logic signed [XY_W-1:0]    up_x,
	input  logic signed [XY_W-1:0]    up_y,
	input  logic signed [ANGLE_BITS:0] up_z,
	input  logic [HEAD_W-1:0]         up_head,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output logic signed [XY_W-1:0]    dn_x,
	output logic signed [XY_W-1:0]    dn_y,
	output logic signed [ANGLE_BITS:0] dn_z,
	output logic [HEAD_W-1:0]         dn_head
);

	localparam logic [32:0] ATAN_FULL = atan_step(STAGE, ANGLE_BITS);
	localparam logic signed [ANGLE_BITS:0] ATAN_Z = ATAN_FULL[ANGLE_BITS:0];

	logic                      valid_q;
	logic signed [XY_W-1:0]    x_q, y_q;
	logic signed [ANGLE_BITS:0] z_q;
	logic [HEAD_W-1:0]         head_q;
	logic signed [XY_W-1:0]    xs, ys, x_nx, y_nx;
	logic signed [ANGLE_BITS:0] z_nx;

	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		xs = up_x >>> STAGE;
		ys = up_y >>> STAGE;
		// A non-negative residual angle rotates anticlockwise.
		if (!up_z[ANGLE_BITS]) begin
			x_nx = up_x - ys;
			y_nx = up_y + xs;
			z_nx = up_z - ATAN_Z;
		end else begin
			x_nx = up_x + ys;
			y_nx = up_y - xs;
			z_nx = up_z + ATAN_Z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			x_q    <= x_nx;
			y_q    <= y_nx;
			z_q    <= z_nx;
			head_q <= up_head;
		end
	end

	assign dn_valid = valid_q;
	assign dn_x     = x_q;
	assign dn_y     = y_q;
	assign dn_z     = z_q;
	assign dn_head  = head_q;

endmodule

>>> rtl/core/dri_sat_acc.sv
// Saturating accumulator register that adds a signed increment on each load.
module dri_sat_acc import dri_pkg::*; #(
	parameter int IN_W  = VEL_W,
	parameter int ACC_W = POS_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic signed [IN_W-1:0]  incr,
	output logic signed [ACC_W-1:0] acc
);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic signed [ACC_W-1:0] acc_q, acc_nx;
	logic signed [ACC_W:0]   sum;

	always_comb begin
		sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(incr);
		// The two top bits differ only when the sum left the range.
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_nx = sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_nx = sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (load) begin
			acc_q <= acc_nx;
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/dead_reckoning_integrator_top.sv
// Dead-reckoning integrator: heading, CORDIC cell chain and velocity and position accumulators.
//
// Usage: each input beat on in_data carries a Q8.8 acceleration and a signed heading step.
// The heading step is added to the heading at the input beat itself; the acceleration is
// resolved along the new heading by a chain of CORDIC_STAGES cells, added to the X and Y
// velocities (Q16.16, saturating) and then to the X and Y positions (Q32.16, saturating).
// Every input beat gives exactly one output beat on out_data, in order.
// A beat passes through the input stage, the register of each CORDIC cell, the velocity stage
// and the output register on its way from the input beat to out_valid.
// Throughput: one beat per cycle while out_ready is high; the only loops are the single adders
// of the heading, velocity and position registers, each closed within one stage.
// Each stage has its own valid bit, so a stalled receiver only blocks the stages that are
// full: in_ready falls once every stage from the input to the output register holds a beat.
// Reset clears the heading, velocities, positions and all valid bits; the block takes an
// input beat as soon as reset is released.
`include "dead_reckoning_integrator_top_defines.svh"

module dead_reckoning_integrator_top import dri_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dri_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output dri_out_t out_data
);

	localparam logic [ANGLE_BITS:0] HALF_TURN = {2'b01, {(ANGLE_BITS-1){1'b0}}};

	// Chain signals: index 0 is the input stage, index k+1 the output of cell k.
	logic [CORDIC_STAGES:0]      cv;
	logic [CORDIC_STAGES:0]      rdy;
	logic signed [XY_W-1:0]      cx [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]      cy [CORDIC_STAGES+1];
	logic signed [ANGLE_BITS:0]  cz [CORDIC_STAGES+1];
	logic [HEAD_W-1:0]           ch [CORDIC_STAGES+1];

	// Input stage.
	logic [HEAD_W-1:0]          heading_q, heading_nx;
	logic [39:0]                head_wide;
	logic [ANGLE_BITS-1:0]      head_scaled;
	logic [1:0]                 quad;
	logic signed [16:0]         accel_f;
	logic signed [34:0]         prod;
	logic signed [ANGLE_BITS:0] z_start;
	logic                       valid_s1;
	logic signed [XY_W-1:0]     x_s1;
	logic signed [ANGLE_BITS:0] z_s1;
	logic [HEAD_W-1:0]          heading_s1;
	logic                       in_take;

	// Velocity and output stages.
	logic signed [XY_W-1:0]  xr, yr;
	logic signed [DX_W-1:0]  dx, dy;
	logic                    vel_valid_q, vel_load;
	logic [HEAD_W-1:0]       vel_head_q;
	logic signed [VEL_W-1:0] vel_x, vel_y;
	logic                    out_valid_q, out_load, out_free;
	logic signed [VEL_W-1:0] out_vel_x_q, out_vel_y_q;
	logic [HEAD_W-1:0]       out_head_q;
	logic signed [POS_W-1:0] pos_x, pos_y;

	assign in_ready = !valid_s1 || rdy[0];
	assign in_take  = in_valid && in_ready;

	always_comb begin
		heading_nx = heading_q + in_data.turn_step;
		// Top ANGLE_BITS bits of the heading, padded with zeros below.
		head_wide   = {heading_nx, 24'b0};
		head_scaled = head_wide[39 -: ANGLE_BITS];
		quad        = head_scaled[ANGLE_BITS-1 -: 2];
		// Second and third quarter turns fold by half a turn and a negated vector.
		case (quad)
			2'b01, 2'b10: begin
				accel_f = -17'(in_data.acceleration);
				z_start = {1'b0, head_scaled} - HALF_TURN;
			end
			2'b11: begin
				accel_f = 17'(in_data.acceleration);
				z_start = {1'b1, head_scaled};
			end
			default: begin
				accel_f = 17'(in_data.acceleration);
				z_start = {1'b0, head_scaled};
			end
		endcase
		prod = 35'(accel_f) * 35'(GAIN_Q16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (in_take) begin
				heading_q <= heading_nx;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_s1       <= prod[XY_W-1:0];
			z_s1       <= z_start;
			heading_s1 <= heading_nx;
		end
	end

	assign cv[0] = valid_s1;
	assign cx[0] = x_s1;
	assign cy[0] = '0;
	assign cz[0] = z_s1;
	assign ch[0] = heading_s1;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		dri_cordic_cell #(
			.STAGE      (k),
			.ANGLE_BITS (ANGLE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (cv[k]),
			.up_ready (rdy[k]),
			.up_x     (cx[k]),
			.up_y     (cy[k]),
			.up_z     (cz[k]),
			.up_head  (ch[k]),
			.dn_valid (cv[k+1]),
			.dn_ready (rdy[k+1]),
			.dn_x     (cx[k+1]),
			.dn_y     (cy[k+1]),
			.dn_z     (cz[k+1]),
			.dn_head  (ch[k+1])
		);
	end

	// Velocity stage: round Q8.24 to Q16.16 and accumulate.
	assign out_free = !out_valid_q || out_ready;
	assign rdy[CORDIC_STAGES] = !vel_valid_q || out_free;
	assign vel_load = cv[CORDIC_STAGES] && rdy[CORDIC_STAGES];
	assign out_load = vel_valid_q && out_free;

	always_comb begin
		xr = cx[CORDIC_STAGES] + XY_W'(128);
		yr = cy[CORDIC_STAGES] + XY_W'(128);
		dx = xr[XY_W-1:8];
		dy = yr[XY_W-1:8];
	end

	dri_sat_acc #(
		.IN_W  (DX_W),
		.ACC_W (VEL_W)
	) u_vel_x (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (vel_load),
		.incr   (dx),
		.acc    (vel_x)
	);

	dri_sat_acc #(
		.IN_W  (DX_W),
		.ACC_W (VEL_W)
	) u_vel_y (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (vel_load),
		.incr   (dy),
		.acc    (vel_y)
	);

	// Output stage: the position registers double as the result register.
	dri_sat_acc #(
		.IN_W  (VEL_W),
		.ACC_W (POS_W)
	) u_pos_x (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.incr   (vel_x),
		.acc    (pos_x)
	);

	dri_sat_acc #(
		.IN_W  (VEL_W),
		.ACC_W (POS_W)
	) u_pos_y (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.incr   (vel_y),
		.acc    (pos_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy[CORDIC_STAGES]) begin
				vel_valid_q <= cv[CORDIC_STAGES];
			end
			if (out_free) begin
				out_valid_q <= vel_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vel_load) begin
			vel_head_q <= ch[CORDIC_STAGES];
		end
		if (out_load) begin
			out_vel_x_q <= vel_x;
			out_vel_y_q <= vel_y;
			out_head_q  <= vel_head_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		out_data.position_x = pos_x;
		out_data.position_y = pos_y;
		out_data.velocity_x = out_vel_x_q;
		out_data.velocity_y = out_vel_y_q;
		out_data.heading    = out_head_q;
	end

	`DRI_ASSERT_NOW(a_full_when_blocked, !in_ready, (&cv) && vel_valid_q && out_valid_q, "input blocked while a stage is empty")
	`DRI_ASSERT_NEXT(a_heading_tagged, in_valid && in_ready, heading_s1 == heading_q, "input stage heading differs from heading register")
	`DRI_ASSERT_NEXT(a_vel_copied, vel_valid_q && out_free, (out_data.velocity_x == $past(vel_x)) && (out_data.velocity_y == $past(vel_y)), "output velocity differs from accumulator")

endmodule
